### rtl/mcr_pkg.sv
// ----------------------------------------------------------------------------
// mcr_pkg: shared types and constants for the motor CAN reply router
// Action codes, the classified command passed from front to back, and the
// driver register list in both directions.
// ----------------------------------------------------------------------------
`default_nettype none

package mcr_pkg;

  localparam int ID_W     = 11;
  localparam int MID_W    = 12;
  localparam int SLOT_W   = 4;
  localparam int IDX_W    = 7;
  localparam int POS_W    = 6;
  localparam int VAL_W    = 32;
  localparam int DATA_W   = 64;
  localparam int ACT_W    = 3;

  localparam int PARAMS_PER_MOTOR = 45;

  localparam logic [7:0]       REPLY_MARK = 8'h33;
  localparam logic [4:0]       FB_OFFSET  = 5'h10;
  localparam logic [POS_W-1:0] POS_LAST   = 6'd44;
  localparam logic [POS_W-1:0] PROG_DONE  = 6'd0;
  localparam logic [POS_W-1:0] PROG_START = 6'd1;
  localparam logic [POS_W-1:0] PROG_MAX   = 6'd45;

  // Configuration register indexes.
  localparam logic CFG_MOTOR_BASE = 1'b0;
  localparam logic CFG_FB_BASE    = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_IGNORED       = 3'd0,
    ACT_FEEDBACK      = 3'd1,
    ACT_STORED        = 3'd2,
    ACT_REPLY_IGNORED = 3'd3,
    ACT_REQUEST       = 3'd4,
    ACT_COMPLETE      = 3'd5
  } act_t;

  typedef enum logic [1:0] {
    CMD_IGNORE,
    CMD_FEEDBACK,
    CMD_REPLY,
    CMD_POLL
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t            op;
    logic [SLOT_W-1:0]  slot;
    logic [MID_W-1:0]   can_id;
    logic [IDX_W-1:0]   reg_index;
    logic               pos_ok;
    logic [POS_W-1:0]   pos;
    logic [VAL_W-1:0]   value;
    logic [DATA_W-1:0]  payload;
  } cmd_t;

  // Position of a driver register in the readout list; MSB flags a listed index.
  function automatic logic [POS_W:0] list_pos(input logic [7:0] idx);
    logic [POS_W:0] r;
    r = '0;
    if (idx <= 8'd36) begin
      r = {1'b1, idx[POS_W-1:0]};
    end else if (idx >= 8'd50 && idx <= 8'd55) begin
      r = {1'b1, POS_W'(idx - 8'd13)};
    end else if (idx == 8'd80) begin
      r = {1'b1, 6'd43};
    end else if (idx == 8'd81) begin
      r = {1'b1, POS_LAST};
    end
    return r;
  endfunction

  // Driver register index at a list position.
  function automatic logic [IDX_W-1:0] reg_at(input logic [POS_W-1:0] pos);
    logic [IDX_W-1:0] r;
    if (pos <= 6'd36) begin
      r = IDX_W'(pos);
    end else if (pos <= 6'd42) begin
      r = IDX_W'(pos) + 7'd13;
    end else if (pos == 6'd43) begin
      r = 7'd80;
    end else begin
      r = 7'd81;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/mcr_chan_if.sv
// ----------------------------------------------------------------------------
// mcr_chan_if: valid/ready channels of the motor CAN reply router
// One interface for input items and one for result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcr_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [10:0] frame_id;
  logic [63:0] frame_data;
  logic [3:0]  slot;

  modport source (output valid, kind, frame_id, frame_data, slot, input ready);
  modport sink   (input valid, kind, frame_id, frame_data, slot, output ready);
endinterface

interface mcr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [3:0]  out_slot;
  logic [11:0] motor_can_id;
  logic [6:0]  reg_index;
  logic [31:0] reg_value;
  logic [63:0] feedback_payload;

  modport source (output valid, action, out_slot, motor_can_id, reg_index, reg_value,
                  feedback_payload, input ready);
  modport sink   (input valid, action, out_slot, motor_can_id, reg_index, reg_value,
                  feedback_payload, output ready);
endinterface

`default_nettype wire

### rtl/motor_can_reply_router_and_param_reader.sv
// ----------------------------------------------------------------------------
// motor_can_reply_router_and_param_reader: CAN reply router and readout sequencer
// Routes feedback frames, stores register replies and answers readout polls.
// ----------------------------------------------------------------------------
//
//   Port     Dir  Handshake     Carries
//   in_ch    in   valid/ready   kind, frame_id, frame_data, slot
//   out_ch   out  valid/ready   action, out_slot, motor_can_id, reg_index,
//                               reg_value, feedback_payload
//   cfg_*    in   cfg_we        cfg_index, cfg_data (motor and feedback id bases)
//
// One item per cycle is sustained while out_ch.ready stays high. An accepted item
// is written into the queue, executed from the queue head, and its result loaded
// into the result register, from which out_ch takes it.
// The rate is set by the progress read-modify-write in the back end.
// After reset the parameter store is cleared, all NUM_MOTORS*45 entries, during
// which in_ch.ready stays low. A two-entry queue lets input continue while
// the result register waits on out_ch.ready.
`default_nettype none

module motor_can_reply_router_and_param_reader import mcr_pkg::*; #(
  parameter int NUM_MOTORS = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic            cfg_index,
  input  wire logic [ID_W-1:0] cfg_data,
  mcr_in_if.sink               in_ch,
  mcr_out_if.source            out_ch
);

  logic [ID_W-1:0] motor_base_id;
  logic [ID_W-1:0] feedback_id_base;
  logic            push;
  cmd_t            push_cmd;
  logic            q_full;
  logic            q_valid;
  logic            pop;
  cmd_t            q_cmd;
  logic            clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_base_id    <= 11'd1;
      feedback_id_base <= 11'd33;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MOTOR_BASE: motor_base_id    <= cfg_data;
        CFG_FB_BASE:    feedback_id_base <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mcr_front #(.NUM_MOTORS(NUM_MOTORS)) u_front (
    .in_ch            (in_ch),
    .motor_base_id    (motor_base_id),
    .feedback_id_base (feedback_id_base),
    .blocked          (clearing),
    .q_full           (q_full),
    .push             (push),
    .push_cmd         (push_cmd)
  );

  mcr_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .valid    (q_valid),
    .pop      (pop),
    .head     (q_cmd)
  );

  mcr_back #(.NUM_MOTORS(NUM_MOTORS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

  // No item is taken while the store is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ch.ready)
    else $error("input accepted during store clear");

  // A result carries a defined action code.
  a_action_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.action <= ACT_W'(ACT_COMPLETE)))
    else $error("undefined action code");

  // An ignored frame names no motor.
  a_ignored_clean: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.action == ACT_W'(ACT_IGNORED)) |->
      (out_ch.out_slot == '0 && out_ch.motor_can_id == '0))
    else $error("ignored result carries a slot");

  // No command is executed while the store is being cleared.
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !pop)
    else $error("command executed during store clear");

endmodule

`default_nettype wire

### rtl/mcr_ram.sv
// ----------------------------------------------------------------------------
// mcr_ram: generic single-port-write RAM
// One write and one read address per cycle, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 180
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/mcr_front.sv
// ----------------------------------------------------------------------------
// mcr_front: input acceptance and frame classification
// Matches feedback ids, decodes register replies and polls into commands.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_front import mcr_pkg::*; #(
  parameter int NUM_MOTORS = 4
) (
  mcr_in_if.sink                  in_ch,
  input  wire logic [ID_W-1:0]    motor_base_id,
  input  wire logic [ID_W-1:0]    feedback_id_base,
  input  wire logic               blocked,
  input  wire logic               q_full,
  output logic                    push,
  output cmd_t                    push_cmd
);

  logic                fb_hit;
  logic [SLOT_W-1:0]   fb_slot;
  logic                mot_hit;
  logic [SLOT_W-1:0]   mot_slot;
  logic [MID_W-1:0]    want_id;
  logic [POS_W:0]      lp;

  assign in_ch.ready = !blocked && !q_full;
  assign push        = in_ch.valid && in_ch.ready;

  assign want_id = {in_ch.frame_data[11:8], in_ch.frame_data[7:0]};
  assign lp      = list_pos(in_ch.frame_data[31:24]);

  // Every slot is compared in parallel; the scan runs downward so the lowest hit wins.
  always_comb begin
    logic [MID_W-1:0] mid_k;
    logic             hit_k;
    fb_hit   = 1'b0;
    fb_slot  = '0;
    mot_hit  = 1'b0;
    mot_slot = '0;
    for (int k = NUM_MOTORS - 1; k >= 0; k--) begin
      mid_k = {1'b0, motor_base_id} + MID_W'(k);
      hit_k = (({1'b0, feedback_id_base} + MID_W'(k)) == {1'b0, in_ch.frame_id}) ||
              (feedback_id_base == '0 &&
               ({1'b0, mid_k} + {8'd0, FB_OFFSET}) == {2'b0, in_ch.frame_id});
      if (hit_k) begin
        fb_hit  = 1'b1;
        fb_slot = SLOT_W'(k);
      end
      if (mid_k == want_id) begin
        mot_hit  = 1'b1;
        mot_slot = SLOT_W'(k);
      end
    end
  end

  always_comb begin
    push_cmd           = '0;
    push_cmd.op        = CMD_IGNORE;
    push_cmd.reg_index = {1'b0, in_ch.frame_data[29:24]};
    push_cmd.pos_ok    = lp[POS_W];
    push_cmd.pos       = lp[POS_W-1:0];
    push_cmd.value     = in_ch.frame_data[63:32];
    push_cmd.payload   = in_ch.frame_data;
    if (in_ch.kind) begin
      if (32'(in_ch.slot) < NUM_MOTORS) begin
        push_cmd.op   = CMD_POLL;
        push_cmd.slot = in_ch.slot;
      end
    end else if (in_ch.frame_id != '0) begin
      if (fb_hit) begin
        push_cmd.op   = CMD_FEEDBACK;
        push_cmd.slot = fb_slot;
      end else if (in_ch.frame_data[23:16] == REPLY_MARK && mot_hit) begin
        push_cmd.op   = CMD_REPLY;
        push_cmd.slot = mot_slot;
      end
    end
    push_cmd.can_id = {1'b0, motor_base_id} + MID_W'(push_cmd.slot);
    // A listed index is below 128, so the low seven bits carry it.
    push_cmd.reg_index = in_ch.frame_data[30:24];
  end

endmodule

`default_nettype wire

### rtl/mcr_fifo.sv
// ----------------------------------------------------------------------------
// mcr_fifo: two-entry command queue
// Decouples classification from execution.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_fifo import mcr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      full,
  output logic      valid,
  input  wire logic pop,
  output cmd_t      head
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

### rtl/mcr_back.sv
// ----------------------------------------------------------------------------
// mcr_back: command execution and result register
// Keeps readout progress per slot, writes the parameter store and forms results.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_back import mcr_pkg::*; #(
  parameter int NUM_MOTORS = 4
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_valid,
  input  cmd_t       q_cmd,
  output logic       pop,
  output logic       clearing,
  mcr_out_if.source  out_ch
);

  localparam int SIDX_W = $clog2(NUM_MOTORS);
  localparam int DEPTH  = NUM_MOTORS * PARAMS_PER_MOTOR;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [POS_W-1:0]  progress [NUM_MOTORS];
  logic [SIDX_W-1:0] sidx;
  logic [POS_W-1:0]  prog_cur;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] store_addr;
  logic [ADDR_W-1:0] ram_addr;
  logic              store_we;
  logic              prog_we;
  logic [POS_W-1:0]  prog_new;
  act_t              act;
  logic [IDX_W-1:0]  res_index;
  logic [VAL_W-1:0]  res_value;
  logic [DATA_W-1:0] res_payload;
  logic [SLOT_W-1:0] res_slot;
  logic [MID_W-1:0]  res_mid;

  assign sidx     = q_cmd.slot[SIDX_W-1:0];
  assign prog_cur = progress[sidx];
  assign pop      = q_valid && !clearing && (!out_ch.valid || out_ch.ready);

  assign store_addr = ADDR_W'(sidx * PARAMS_PER_MOTOR) + ADDR_W'(q_cmd.pos);
  assign ram_addr   = clearing ? clr_addr : store_addr;

  always_comb begin
    act         = ACT_IGNORED;
    res_slot    = q_cmd.slot;
    res_mid     = q_cmd.can_id;
    res_index   = '0;
    res_value   = '0;
    res_payload = '0;
    store_we    = 1'b0;
    prog_we     = 1'b0;
    prog_new    = (q_cmd.pos == POS_LAST) ? PROG_DONE : q_cmd.pos + 6'd2;
    case (q_cmd.op)
      CMD_IGNORE: begin
        res_slot = '0;
        res_mid  = '0;
      end
      CMD_FEEDBACK: begin
        act         = ACT_FEEDBACK;
        res_payload = q_cmd.payload;
      end
      CMD_REPLY: begin
        if (prog_cur == PROG_DONE || !q_cmd.pos_ok) begin
          act = ACT_REPLY_IGNORED;
        end else begin
          act       = ACT_STORED;
          res_index = q_cmd.reg_index;
          res_value = q_cmd.value;
          store_we  = 1'b1;
          prog_we   = 1'b1;
        end
      end
      CMD_POLL: begin
        if (prog_cur == PROG_DONE || prog_cur > PROG_MAX) begin
          act = ACT_COMPLETE;
        end else begin
          act       = ACT_REQUEST;
          res_index = reg_at(prog_cur - 6'd1);
        end
      end
      default: begin
        res_slot = '0;
        res_mid  = '0;
      end
    endcase
  end

  // After reset the store is swept to zero, one entry a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_MOTORS; k++) begin
        progress[k] <= PROG_START;
      end
    end else if (pop && prog_we) begin
      progress[sidx] <= prog_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (pop) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_ch.action           <= ACT_W'(act);
      out_ch.out_slot         <= res_slot;
      out_ch.motor_can_id     <= res_mid;
      out_ch.reg_index        <= res_index;
      out_ch.reg_value        <= res_value;
      out_ch.feedback_payload <= res_payload;
    end
  end

  mcr_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (clearing || (pop && store_we)),
    .wr_addr (ram_addr),
    .wr_data (clearing ? '0 : q_cmd.value),
    .rd_addr (ram_addr),
    .rd_data ()
  );

endmodule

`default_nettype wire
